FILE: rtl/hbb_pkg.sv
// ----------------------------------------------------------------------------
// hbb_pkg
// Shared widths, codes and lane control bundle of the horizontal box blur.
// ----------------------------------------------------------------------------
package hbb_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_W          = 5;
    localparam int DEF_MAX_RADIUS = 16;
    localparam int NUM_LANES      = 3;

    localparam int LANE_BLUE  = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_RED   = 2;

    localparam logic [CFG_W-1:0] RADIUS_RESET = CFG_W'(1);

    typedef enum logic [1:0] {
        SUM_HOLD,
        SUM_INIT,
        SUM_SLIDE
    } t_sum_op;

    typedef struct packed {
        logic    load_px;
        logic    load_first;
        logic    rd_en;
        logic    wr_en;
        t_sum_op sum_op;
        logic    sub_first;
        logic    push;
        logic    row_end;
    } t_lane_ctl;

endpackage

FILE: rtl/horizontal_box_blur.sv
// ----------------------------------------------------------------------------
// horizontal_box_blur
// Streaming horizontal box blur of RGB rows with edge replication.
// ----------------------------------------------------------------------------
// Pixels of one row arrive in raster order; each result is the truncated
// per-channel mean of the 2R+1 pixels centred on its column, where R is
// the radius register (values above MAX_RADIUS act as MAX_RADIUS) sampled
// at the first pixel of each row. Result column k-R leaves when input
// column k arrives; the pixel marked last in row flushes the remaining
// columns and the final one carries row_end. Each pixel first reads the
// old window entry from the per-channel window memory, then slides the
// running sums. After the last pixel of a row, the sums slide once more
// for each pixel the row lacks to reach R+1 pixels, and each flushed
// result but the final one is followed by a read of one window entry.
// The means come from a multiply by the row's reciprocal and pass the
// product stage and then the result register on their way out; these
// let new pixels enter while results wait. No clearing pass after reset.
// ----------------------------------------------------------------------------
module horizontal_box_blur #(
    parameter int MAX_RADIUS = hbb_pkg::DEF_MAX_RADIUS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [hbb_pkg::PIX_W-1:0] i_in_blue,
    input  logic [hbb_pkg::PIX_W-1:0] i_in_green,
    input  logic [hbb_pkg::PIX_W-1:0] i_in_red,
    input  logic                      i_last_in_row,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [hbb_pkg::PIX_W-1:0] o_out_blue,
    output logic [hbb_pkg::PIX_W-1:0] o_out_green,
    output logic [hbb_pkg::PIX_W-1:0] o_out_red,
    output logic                      o_row_end,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [hbb_pkg::CFG_W-1:0] i_cfg_radius
);
    import hbb_pkg::*;

    localparam int DEPTH   = 2 * MAX_RADIUS + 1;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int N_W     = $clog2(DEPTH + 1);
    localparam int SUM_W   = $clog2(((1 << PIX_W) - 1) * DEPTH + 1);
    localparam int RECIP_W = SUM_W + N_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;

    t_lane_ctl          ctl;
    logic               push_ok;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [N_W-1:0]     win_n;
    logic [RECIP_W-1:0] recip;
    logic [PIX_W-1:0]   px   [NUM_LANES];
    logic [PROD_W-1:0]  prod [NUM_LANES];
    logic [PIX_W-1:0]   outv [NUM_LANES];

    assign px[LANE_BLUE]  = i_in_blue;
    assign px[LANE_GREEN] = i_in_green;
    assign px[LANE_RED]   = i_in_red;

    hbb_ctrl #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_last_in_row (i_last_in_row),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_radius  (i_cfg_radius),
        .i_push_ok     (push_ok),
        .o_ctl         (ctl),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .o_n           (win_n),
        .o_recip       (recip)
    );

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        hbb_lane #(
            .MAX_RADIUS (MAX_RADIUS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_px      (px[l]),
            .i_rd_addr (rd_addr),
            .i_wr_addr (wr_addr),
            .i_n       (win_n),
            .i_recip   (recip),
            .o_prod    (prod[l])
        );
    end

    hbb_merge #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_prod    (prod),
        .o_push_ok (push_ok),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_out     (outv),
        .o_row_end (o_row_end)
    );

    assign o_out_blue  = outv[LANE_BLUE];
    assign o_out_green = outv[LANE_GREEN];
    assign o_out_red   = outv[LANE_RED];

endmodule

FILE: rtl/hbb_lane.sv
// ----------------------------------------------------------------------------
// hbb_lane
// One color channel: window memory, running window sum and the
// reciprocal multiply that forms the mean.
// ----------------------------------------------------------------------------
module hbb_lane #(
    parameter int MAX_RADIUS = hbb_pkg::DEF_MAX_RADIUS
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  hbb_pkg::t_lane_ctl                         i_ctl,
    input  logic [hbb_pkg::PIX_W-1:0]                  i_px,
    input  logic [$clog2(2*MAX_RADIUS+1)-1:0]          i_rd_addr,
    input  logic [$clog2(2*MAX_RADIUS+1)-1:0]          i_wr_addr,
    input  logic [$clog2(2*MAX_RADIUS+2)-1:0]          i_n,
    input  logic [$clog2(((1 << hbb_pkg::PIX_W) - 1) * (2*MAX_RADIUS+1) + 1)
                  + $clog2(2*MAX_RADIUS+2):0]          i_recip,
    output logic [2*$clog2(((1 << hbb_pkg::PIX_W) - 1) * (2*MAX_RADIUS+1) + 1)
                  + $clog2(2*MAX_RADIUS+2):0]          o_prod
);
    import hbb_pkg::*;

    localparam int DEPTH   = 2 * MAX_RADIUS + 1;
    localparam int N_W     = $clog2(DEPTH + 1);
    localparam int SUM_W   = $clog2(((1 << PIX_W) - 1) * DEPTH + 1);
    localparam int RECIP_W = SUM_W + N_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;

    logic [PIX_W-1:0]     r_mem [DEPTH];
    logic [PIX_W-1:0]     r_rd;
    logic [PIX_W-1:0]     r_px;
    logic [PIX_W-1:0]     r_p0;
    logic [SUM_W-1:0]     r_sum;
    logic [PROD_W-1:0]    r_prod;

    logic [N_W+PIX_W-1:0] init_sum;
    logic [PIX_W-1:0]     sub_px;
    logic [SUM_W-1:0]     slide_sum;
    logic [SUM_W-1:0]     n_sum;
    logic [PROD_W-1:0]    prod_full;

    assign init_sum  = i_n * r_px;
    assign sub_px    = i_ctl.sub_first ? r_p0 : r_rd;
    assign slide_sum = r_sum + SUM_W'(r_px) - SUM_W'(sub_px);
    assign prod_full = r_sum * i_recip;

    always_comb begin
        case (i_ctl.sum_op)
            SUM_INIT:  n_sum = SUM_W'(init_sum);
            SUM_SLIDE: n_sum = slide_sum;
            default:   n_sum = r_sum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= r_px;
        end
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_px) begin
            r_px <= i_px;
        end
        if (i_ctl.load_first) begin
            r_p0 <= i_px;
        end
        if (i_ctl.push) begin
            r_prod <= prod_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/hbb_merge.sv
// ----------------------------------------------------------------------------
// hbb_merge
// Joins the three lane products into one result item: takes the quotient
// bits, attaches the row-end mark and holds the item for the output.
// ----------------------------------------------------------------------------
module hbb_merge #(
    parameter int MAX_RADIUS = hbb_pkg::DEF_MAX_RADIUS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hbb_pkg::t_lane_ctl        i_ctl,
    input  logic [2*$clog2(((1 << hbb_pkg::PIX_W) - 1) * (2*MAX_RADIUS+1) + 1)
                  + $clog2(2*MAX_RADIUS+2):0] i_prod [hbb_pkg::NUM_LANES],
    output logic                      o_push_ok,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [hbb_pkg::PIX_W-1:0] o_out [hbb_pkg::NUM_LANES],
    output logic                      o_row_end
);
    import hbb_pkg::*;

    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int N_W   = $clog2(DEPTH + 1);
    localparam int SUM_W = $clog2(((1 << PIX_W) - 1) * DEPTH + 1);
    localparam int SHIFT = SUM_W + N_W;

    logic             r_s1_valid;
    logic             r_s1_row_end;
    logic             r_o_valid;
    logic             r_o_row_end;
    logic [PIX_W-1:0] r_out [NUM_LANES];
    logic             s1_adv;

    assign s1_adv    = r_s1_valid && (!r_o_valid || i_ready);
    assign o_push_ok = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_ctl.push) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_s1_row_end <= i_ctl.row_end;
        end
        if (s1_adv) begin
            r_o_row_end <= r_s1_row_end;
            for (int l = 0; l < NUM_LANES; l++) begin
                r_out[l] <= i_prod[l][SHIFT +: PIX_W];
            end
        end
    end

    assign o_valid   = r_o_valid;
    assign o_row_end = r_o_row_end;
    assign o_out     = r_out;

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> o_push_ok)
        else $error("result pushed into a full product stage");

    a_out_fed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_s1_valid))
        else $error("output item appeared without a product behind it");

endmodule

FILE: rtl/hbb_ctrl.sv
// ----------------------------------------------------------------------------
// hbb_ctrl
// Row sequencer: radius register, pixel count, window slot, flush walk
// and the per-cycle commands to the lanes.
// ----------------------------------------------------------------------------
module hbb_ctrl #(
    parameter int MAX_RADIUS = hbb_pkg::DEF_MAX_RADIUS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_last_in_row,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hbb_pkg::CFG_W-1:0]            i_cfg_radius,
    input  logic                                 i_push_ok,
    output hbb_pkg::t_lane_ctl                   o_ctl,
    output logic [$clog2(2*MAX_RADIUS+1)-1:0]    o_rd_addr,
    output logic [$clog2(2*MAX_RADIUS+1)-1:0]    o_wr_addr,
    output logic [$clog2(2*MAX_RADIUS+2)-1:0]    o_n,
    output logic [$clog2(((1 << hbb_pkg::PIX_W) - 1) * (2*MAX_RADIUS+1) + 1)
                  + $clog2(2*MAX_RADIUS+2):0]    o_recip
);
    import hbb_pkg::*;

    localparam int DEPTH   = 2 * MAX_RADIUS + 1;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int AW1     = ADDR_W + 1;
    localparam int N_W     = $clog2(DEPTH + 1);
    localparam int K_W     = N_W;
    localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
    localparam int SUM_W   = $clog2(((1 << PIX_W) - 1) * DEPTH + 1);
    localparam int SHIFT   = SUM_W + N_W;
    localparam int RECIP_W = SHIFT + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_FLUSH,
        S_ADV
    } t_state;

    logic [RECIP_W-1:0] recip_tab [MAX_RADIUS+1];

    for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_recip
        localparam longint NDIV = 2 * g + 1;
        localparam logic [RECIP_W-1:0] RECIP =
            RECIP_W'(((longint'(1) << SHIFT) + NDIV - 1) / NDIV);
        assign recip_tab[g] = RECIP;
    end

    t_state              r_state,  n_state;
    logic [CFG_W-1:0]    r_radius;
    logic [K_W-1:0]      r_cnt,    n_cnt;
    logic [K_W-1:0]      r_k,      n_k;
    logic                r_last,   n_last;
    logic [RAD_W-1:0]    r_rad,    n_rad;
    logic [N_W-1:0]      r_n,      n_n;
    logic [RECIP_W-1:0]  r_recip,  n_recip;
    logic [ADDR_W-1:0]   r_w,      n_w;
    logic [RAD_W-1:0]    r_e,      n_e;
    logic                r_pend,   n_pend;

    t_lane_ctl           ctl;
    logic                ready;
    logic [RAD_W-1:0]    rad_clamp;
    logic [ADDR_W-1:0]   slot_next;
    logic [K_W-1:0]      twice_rad;
    logic [K_W-1:0]      reach;
    logic [ADDR_W-1:0]   reach_a;
    logic [ADDR_W-1:0]   fl_addr;
    logic [ADDR_W-1:0]   rd_addr;

    assign rad_clamp = (int'(r_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                      : RAD_W'(r_radius);
    assign twice_rad = K_W'({r_rad, 1'b0});
    assign reach     = K_W'(r_e) + K_W'(r_rad);
    assign reach_a   = ADDR_W'(reach);

    always_comb begin
        if (r_cnt == '0) begin
            slot_next = '0;
        end else if (N_W'(r_w) == r_n - N_W'(1)) begin
            slot_next = '0;
        end else begin
            slot_next = r_w + ADDR_W'(1);
        end
        if (r_w >= reach_a) begin
            fl_addr = r_w - reach_a;
        end else begin
            fl_addr = ADDR_W'(AW1'(r_w) + AW1'(r_n) - AW1'(reach_a));
        end
    end

    always_comb begin
        ctl            = '0;
        ctl.sum_op     = SUM_HOLD;
        ready          = 1'b0;
        rd_addr        = slot_next;
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_k            = r_k;
        n_last         = r_last;
        n_rad          = r_rad;
        n_n            = r_n;
        n_recip        = r_recip;
        n_w            = r_w;
        n_e            = r_e;
        n_pend         = r_pend;
        case (r_state)
            S_IDLE: begin
                ctl.push = r_pend && i_push_ok;
                ready    = !r_pend || i_push_ok;
                if (ctl.push) begin
                    n_pend = 1'b0;
                end
                if (i_valid && ready) begin
                    ctl.load_px    = 1'b1;
                    ctl.load_first = (r_cnt == '0);
                    ctl.rd_en      = 1'b1;
                    n_w            = slot_next;
                    n_k            = r_cnt;
                    n_last         = i_last_in_row;
                    if (i_last_in_row) begin
                        n_cnt = '0;
                    end else if (r_cnt != K_W'(DEPTH)) begin
                        n_cnt = r_cnt + K_W'(1);
                    end
                    if (r_cnt == '0) begin
                        n_rad   = rad_clamp;
                        n_n     = N_W'({rad_clamp, 1'b1});
                        n_recip = recip_tab[rad_clamp];
                    end
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                ctl.wr_en     = 1'b1;
                ctl.sum_op    = (r_k == '0) ? SUM_INIT : SUM_SLIDE;
                ctl.sub_first = (r_k <= twice_rad);
                if (r_last) begin
                    n_e     = r_rad;
                    n_state = S_FLUSH;
                end else begin
                    n_pend  = (r_k >= K_W'(r_rad));
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (K_W'(r_e) > r_k) begin
                    ctl.sum_op    = SUM_SLIDE;
                    ctl.sub_first = 1'b1;
                    n_e           = r_e - RAD_W'(1);
                end else begin
                    ctl.push    = i_push_ok;
                    ctl.row_end = (r_e == '0);
                    if (i_push_ok) begin
                        if (r_e == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            ctl.rd_en = 1'b1;
                            rd_addr   = fl_addr;
                            n_state   = S_ADV;
                        end
                    end
                end
            end
            S_ADV: begin
                ctl.sum_op    = SUM_SLIDE;
                ctl.sub_first = (r_k < reach);
                n_e           = r_e - RAD_W'(1);
                n_state       = S_FLUSH;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_radius <= RADIUS_RESET;
            r_cnt    <= '0;
            r_rad    <= '0;
            r_n      <= N_W'(1);
            r_w      <= '0;
            r_e      <= '0;
            r_pend   <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_radius <= i_cfg_radius;
            end
            r_cnt  <= n_cnt;
            r_rad  <= n_rad;
            r_n    <= n_n;
            r_w    <= n_w;
            r_e    <= n_e;
            r_pend <= n_pend;
            r_last <= n_last;
        end
        r_k     <= n_k;
        r_recip <= n_recip;
    end

    assign o_ready     = ready;
    assign o_cfg_ready = 1'b1;
    assign o_ctl       = ctl;
    assign o_rd_addr   = rd_addr;
    assign o_wr_addr   = r_w;
    assign o_n         = r_n;
    assign o_recip     = r_recip;

    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && ready) |=> (r_state == S_UPD))
        else $error("accepted item did not move to the window update");

    a_flush_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH || r_state == S_ADV) |-> (r_e <= r_rad))
        else $error("flush centre beyond the row radius");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (N_W'(r_w) < r_n))
        else $error("window slot outside the row window");

    a_row_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.push && ctl.row_end) |=> (r_state == S_IDLE && r_cnt == '0))
        else $error("row end pushed but row state not restarted");

endmodule

FILE: dv/horizontal_box_blur_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// horizontal_box_blur_tb
// Self-checking testbench for the streaming horizontal box blur.
// ----------------------------------------------------------------------------
// Rows of RGB pixels go in over a valid/ready channel while the radius
// register is changed between rows, and also in the middle of rows. A
// behavioral blur model keeps the pixels of the current row and, for each
// accepted pixel, queues the blurred columns it releases. Every result
// leaving the block is compared with the oldest queued column. Both sides
// stall in random bursts except during the closing stretch of the run.
// ----------------------------------------------------------------------------
module horizontal_box_blur_tb;

    import hbb_pkg::*;

    localparam int MAX_RAD       = DEF_MAX_RADIUS;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 450;
    localparam int QUIET_FROM    = 400;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             row_end;
    } t_blur_px;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [PIX_W-1:0] i_in_blue;
    logic [PIX_W-1:0] i_in_green;
    logic [PIX_W-1:0] i_in_red;
    logic             i_last_in_row;
    logic             o_valid;
    logic             i_ready;
    logic [PIX_W-1:0] o_out_blue;
    logic [PIX_W-1:0] o_out_green;
    logic [PIX_W-1:0] o_out_red;
    logic             o_row_end;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_radius;

    t_blur_px          blurred_q[$];
    logic [3*PIX_W-1:0] row_px[$];
    logic [CFG_W-1:0]  radius_reg;
    int                row_radius;
    int                error_count;
    int                pixels_sent;
    bit                quiet;
    int                stall_left;

    horizontal_box_blur #(
        .MAX_RADIUS(MAX_RAD)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_blue     (i_in_blue),
        .i_in_green    (i_in_green),
        .i_in_red      (i_in_red),
        .i_last_in_row (i_last_in_row),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_blue    (o_out_blue),
        .o_out_green   (o_out_green),
        .o_out_red     (o_out_red),
        .o_row_end     (o_row_end),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_radius  (i_cfg_radius)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_blur_px blur_column(int col, int last_col, bit at_end);
        t_blur_px res;
        int sb;
        int sg;
        int sr;
        int idx;
        int width;
        sb = 0;
        sg = 0;
        sr = 0;
        width = 2 * row_radius + 1;
        for (int j = col - row_radius; j <= col + row_radius; j++) begin
            idx = (j < 0) ? 0 : ((j > last_col) ? last_col : j);
            sb += row_px[idx][7:0];
            sg += row_px[idx][15:8];
            sr += row_px[idx][23:16];
        end
        res.blue    = PIX_W'(sb / width);
        res.green   = PIX_W'(sg / width);
        res.red     = PIX_W'(sr / width);
        res.row_end = at_end;
        return res;
    endfunction

    task automatic predict_blur(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                                logic [PIX_W-1:0] r, bit last);
        int newest;
        int first_col;
        if (row_px.size() == 0)
            row_radius = (int'(radius_reg) > MAX_RAD) ? MAX_RAD : int'(radius_reg);
        row_px.push_back({r, g, b});
        newest = row_px.size() - 1;
        if (last) begin
            first_col = newest - ((newest < row_radius) ? newest : row_radius);
            for (int c = first_col; c <= newest; c++)
                blurred_q.push_back(blur_column(c, newest, c == newest));
            row_px.delete();
        end else if (newest >= row_radius) begin
            blurred_q.push_back(blur_column(newest - row_radius, newest, 1'b0));
        end
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                              logic [PIX_W-1:0] r, bit last);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_in_blue     <= b;
        i_in_green    <= g;
        i_in_red      <= r;
        i_last_in_row <= last;
        do @(posedge i_clk); while (!o_ready);
        predict_blur(b, g, r, last);
        pixels_sent++;
    endtask

    task automatic send_random_pixel(bit last);
        send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), last);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (blurred_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_radius(logic [CFG_W-1:0] value);
        drain_results();
        i_cfg_valid  <= 1'b1;
        i_cfg_radius <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        radius_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_default_radius();
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd128, 1'b1);
    endtask

    task automatic test_zero_radius();
        write_radius(CFG_W'(0));
        send_pixel(8'd1, 8'd254, 8'd127, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    endtask

    task automatic test_short_rows_max_radius();
        write_radius(CFG_W'(MAX_RAD));
        send_pixel(8'd200, 8'd100, 8'd50, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd170, 8'd85, 8'd3, 1'b1);
    endtask

    task automatic test_radius_above_max();
        write_radius(CFG_W'(31));
        send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd77, 8'd13, 8'd240, 1'b1);
    endtask

    task automatic test_mid_row_radius();
        write_radius(CFG_W'(2));
        repeat (3) send_random_pixel(1'b0);
        write_radius(CFG_W'(5));
        repeat (2) send_random_pixel(1'b0);
        send_random_pixel(1'b1);
        repeat (3) send_random_pixel(1'b0);
        send_random_pixel(1'b1);
    endtask

    task automatic test_random_rows();
        int start;
        int sel;
        int nrows;
        int len;
        logic [CFG_W-1:0] next_radius;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            next_radius = radius_reg;
            if (sel <= 5)
                next_radius = CFG_W'($urandom_range(0, 4));
            else if (sel == 6)
                next_radius = CFG_W'(MAX_RAD);
            else if (sel == 7)
                next_radius = CFG_W'($urandom_range(MAX_RAD + 1, 31));
            else if (sel == 8)
                next_radius = CFG_W'($urandom_range(5, MAX_RAD - 1));
            if (next_radius != radius_reg)
                write_radius(next_radius);
            nrows = $urandom_range(1, 4);
            for (int row = 0; row < nrows; row++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 70)
                                                  : $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    if (pixels_sent - start >= QUIET_FROM)
                        quiet = 1'b1;
                    if (i == len / 2 && len > 2 && $urandom_range(0, 9) == 0)
                        write_radius(CFG_W'($urandom_range(0, 31)));
                    send_random_pixel(i == len - 1);
                end
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 7);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_blur_px want;
        if (i_rst_n && o_valid && i_ready) begin
            if (blurred_q.size() == 0) begin
                $display("%0t: unexpected result b=%0d g=%0d r=%0d end=%0d", $time,
                         o_out_blue, o_out_green, o_out_red, o_row_end);
                error_count++;
            end else begin
                want = blurred_q.pop_front();
                if (want.blue != o_out_blue || want.green != o_out_green ||
                    want.red != o_out_red || want.row_end != o_row_end) begin
                    $display("%0t: expected %0d %0d %0d %0d, actual %0d %0d %0d %0d",
                             $time, want.blue, want.green, want.red, want.row_end,
                             o_out_blue, o_out_green, o_out_red, o_row_end);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_in_blue     = '0;
        i_in_green    = '0;
        i_in_red      = '0;
        i_last_in_row = 1'b0;
        i_ready       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_radius  = '0;
        radius_reg    = RADIUS_RESET;
        row_radius    = 0;
        error_count   = 0;
        pixels_sent   = 0;
        quiet         = 1'b0;
        stall_left    = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_radius();
        test_zero_radius();
        test_short_rows_max_radius();
        test_radius_above_max();
        test_mid_row_radius();
        test_random_rows();
        drain_results();

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
rtl/hbb_pkg.sv
rtl/hbb_lane.sv
rtl/hbb_merge.sv
rtl/hbb_ctrl.sv
rtl/horizontal_box_blur.sv
dv/horizontal_box_blur_tb.sv
